### sv/aarm_pkg.sv
// package for the axis-angle rotation matrix core
// holds the cordic arctangent table, fixed widths and the front/back queue entry type
// no dependencies
package aarm_pkg;

    localparam int TabLen     = 24;
    localparam int CordicFrac = 30;
    localparam int CordicW    = 34;
    localparam int AxisW      = 16;
    localparam int AngleW     = 16;
    localparam int OutW       = 18;
    localparam logic [CordicW-1:0] CordicStart = 34'h026DD3B6A;

    typedef struct packed {
        logic signed [AxisW-1:0] x;
        logic signed [AxisW-1:0] y;
        logic signed [AxisW-1:0] z;
        logic [1:0]              quad;
        logic signed [AngleW-1:0] resid;
    } t_front_item;

    function automatic logic [CordicW-1:0] atan_entry(input logic [4:0] i);
        logic [CordicW-1:0] v;
        unique case (i)
            5'd0:  v = 34'h020000000;
            5'd1:  v = 34'h012E4051E;
            5'd2:  v = 34'h009FB385B;
            5'd3:  v = 34'h0051111D4;
            5'd4:  v = 34'h0028B0D43;
            5'd5:  v = 34'h00145D7E1;
            5'd6:  v = 34'h000A2F61E;
            5'd7:  v = 34'h000517C55;
            5'd8:  v = 34'h00028BE53;
            5'd9:  v = 34'h000145F2F;
            5'd10: v = 34'h0000A2F98;
            5'd11: v = 34'h0000517CC;
            5'd12: v = 34'h000028BE6;
            5'd13: v = 34'h0000145F3;
            5'd14: v = 34'h00000A2FA;
            5'd15: v = 34'h00000517D;
            5'd16: v = 34'h0000028BE;
            5'd17: v = 34'h00000145F;
            5'd18: v = 34'h000000A30;
            5'd19: v = 34'h000000518;
            5'd20: v = 34'h00000028C;
            5'd21: v = 34'h000000146;
            5'd22: v = 34'h0000000A3;
            5'd23: v = 34'h000000051;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

### sv/aarm_front.sv
// front part: accepts requests, folds the angle to a quadrant and residual
// depends on aarm_pkg
module aarm_front import aarm_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic signed [AxisW-1:0]  i_axis_x,
    input  logic signed [AxisW-1:0]  i_axis_y,
    input  logic signed [AxisW-1:0]  i_axis_z,
    input  logic [AngleW-1:0]        i_angle,
    output logic                     o_valid,
    input  logic                     i_ready,
    output t_front_item              o_item
);

    localparam int Depth = 2;

    t_front_item r_mem [Depth];
    logic        r_wp, r_rp;
    logic [1:0]  r_cnt;
    t_front_item w_new;
    logic [AngleW-1:0] w_sum, w_res;
    logic        w_push, w_pop;

    always_comb begin
        w_sum = i_angle + 16'h2000;
        w_new.x = i_axis_x;
        w_new.y = i_axis_y;
        w_new.z = i_axis_z;
        w_new.quad = w_sum[15:14];
        w_res = i_angle - {w_sum[15:14], 14'd0};
        w_new.resid = w_res;
    end

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_item  = r_mem[r_rp];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) r_mem[r_wp] <= w_new;
    end

    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n) r_cnt != 2'd3)
        else $error("queue count overflow");
    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd2 && !w_pop) |=> (r_cnt == 2'd2))
        else $error("full queue lost a request");
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd0 && !w_push) |=> !o_valid)
        else $error("empty queue shows a request");

endmodule

### sv/aarm_back.sv
// back part: iterative cordic, then the nine matrix elements one after another
// depends on aarm_pkg
module aarm_back import aarm_pkg::*; #(
    parameter int FRAC_BITS       = 14,
    parameter int TRIG_ITERATIONS = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  t_front_item     i_item,
    output logic            o_valid,
    input  logic            i_ready,
    output logic [OutW-1:0] o_m [9]
);

    localparam int Iters = (TRIG_ITERATIONS > TabLen) ? TabLen : TRIG_ITERATIONS;
    localparam int CW    = FRAC_BITS + 3;
    localparam int AccW  = 2 * AxisW + CW + FRAC_BITS + 4;
    localparam int CSh   = CordicFrac - FRAC_BITS;
    localparam int RSh   = 2 * FRAC_BITS;

    localparam logic [2:0] StIdle = 3'd0;
    localparam logic [2:0] StCord = 3'd1;
    localparam logic [2:0] StRnd  = 3'd2;
    localparam logic [2:0] StElem = 3'd3;
    localparam logic [2:0] StOut  = 3'd4;

    logic [2:0] r_st;
    logic [4:0] r_it;
    logic [3:0] r_el;
    logic signed [CordicW-1:0] r_cx, r_cy, r_cz;
    logic signed [AxisW-1:0] r_x, r_y, r_z;
    logic [1:0] r_q;
    logic signed [CW-1:0] r_c, r_s, r_t;
    logic signed [AxisW-1:0] r_a, r_b, r_d;
    logic r_diag, r_neg;
    logic signed [2*AxisW:0] r_ab;
    logic r_pv;
    logic [3:0] r_pel;
    logic [OutW-1:0] r_m [9];
    logic [OutW-1:0] r_o [9];
    logic r_ov;

    logic signed [CordicW-1:0] w_dx, w_dy, w_c30, w_s30;
    logic signed [CordicW-1:0] w_cr, w_sr;
    logic signed [AccW-1:0] w_one, w_acc, w_rnd;
    logic [OutW-1:0] w_sat;

    assign o_ready = (r_st == StIdle);
    assign o_valid = r_ov;
    assign o_m     = r_o;
    assign w_dx = r_cy >>> r_it;
    assign w_dy = r_cx >>> r_it;
    assign w_one = AccW'(1) <<< FRAC_BITS;

    always_comb begin
        unique case (r_q)
            2'd0: begin w_c30 = r_cx;  w_s30 = r_cy;  end
            2'd1: begin w_c30 = -r_cy; w_s30 = r_cx;  end
            2'd2: begin w_c30 = -r_cx; w_s30 = -r_cy; end
            default: begin w_c30 = r_cy; w_s30 = -r_cx; end
        endcase
        w_cr = (w_c30 + (CordicW'(1) <<< (CSh - 1))) >>> CSh;
        w_sr = (w_s30 + (CordicW'(1) <<< (CSh - 1))) >>> CSh;
    end

    always_comb begin
        if (r_diag) begin
            w_acc = AccW'(r_ab) * w_one + (w_one * w_one - AccW'(r_ab)) * AccW'(r_c);
        end else begin
            w_acc = AccW'(r_ab) * AccW'(r_t)
                  + (r_neg ? -(AccW'(r_d) * AccW'(r_s)) : AccW'(r_d) * AccW'(r_s)) * w_one;
        end
        w_rnd = (w_acc + (AccW'(1) <<< (RSh - 1))) >>> RSh;
        if (w_rnd > AccW'(131071))       w_sat = 18'h1FFFF;
        else if (w_rnd < -AccW'(131072)) w_sat = 18'h20000;
        else                             w_sat = w_rnd[OutW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= StIdle;
            r_ov <= 1'b0;
            r_pv <= 1'b0;
        end else begin
            if (r_ov && i_ready) r_ov <= 1'b0;
            unique case (r_st)
                StIdle: if (i_valid) r_st <= StCord;
                StCord: if (r_it == 5'(Iters - 1)) r_st <= StRnd;
                StRnd:  r_st <= StElem;
                StElem: if (r_pv && r_pel == 4'd8) r_st <= StOut;
                StOut:  if (!r_ov) begin r_ov <= 1'b1; r_st <= StIdle; end
                default: r_st <= StIdle;
            endcase
            r_pv <= (r_st == StElem) && (r_el != 4'd9);
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_st)
            StIdle: begin
                r_cx <= CordicStart;
                r_cy <= '0;
                r_cz <= CordicW'(i_item.resid) <<< 16;
                r_x <= i_item.x; r_y <= i_item.y; r_z <= i_item.z;
                r_q <= i_item.quad;
                r_it <= '0;
            end
            StCord: begin
                if (!r_cz[CordicW-1]) begin
                    r_cx <= r_cx - w_dx; r_cy <= r_cy + w_dy; r_cz <= r_cz - atan_entry(r_it);
                end else begin
                    r_cx <= r_cx + w_dx; r_cy <= r_cy - w_dy; r_cz <= r_cz + atan_entry(r_it);
                end
                r_it <= r_it + 5'd1;
            end
            StRnd: begin
                r_c  <= CW'(w_cr);
                r_s  <= CW'(w_sr);
                r_t  <= CW'((CordicW'(1) <<< FRAC_BITS) - w_cr);
                r_el <= '0;
            end
            default: ;
        endcase
        if (r_st == StElem && r_el != 4'd9) begin
            r_el <= r_el + 4'd1;
            r_pel <= r_el;
            unique case (r_el)
                4'd0: begin r_ab <= r_x*r_x; r_diag <= 1'b1; end
                4'd1: begin r_ab <= r_x*r_y; r_d <= r_z; r_neg <= 1'b1; r_diag <= 1'b0; end
                4'd2: begin r_ab <= r_x*r_z; r_d <= r_y; r_neg <= 1'b0; r_diag <= 1'b0; end
                4'd3: begin r_ab <= r_y*r_x; r_d <= r_z; r_neg <= 1'b0; r_diag <= 1'b0; end
                4'd4: begin r_ab <= r_y*r_y; r_diag <= 1'b1; end
                4'd5: begin r_ab <= r_y*r_z; r_d <= r_x; r_neg <= 1'b1; r_diag <= 1'b0; end
                4'd6: begin r_ab <= r_z*r_x; r_d <= r_y; r_neg <= 1'b1; r_diag <= 1'b0; end
                4'd7: begin r_ab <= r_z*r_y; r_d <= r_x; r_neg <= 1'b0; r_diag <= 1'b0; end
                default: begin r_ab <= r_z*r_z; r_diag <= 1'b1; end
            endcase
        end
        if (r_pv) r_m[r_pel] <= w_sat;
        if (r_st == StOut && !r_ov) r_o <= r_m;
    end

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !i_ready) |=> r_ov)
        else $error("result dropped before taken");
    a_it: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == StCord) |-> (r_it < 5'(Iters)))
        else $error("cordic ran past its iteration count");
    a_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == StIdle && i_valid) |=> (r_st == StCord))
        else $error("request not started");

endmodule

### sv/axis_angle_rotation_matrix_core.sv
// Axis-angle rotation matrix core: takes an axis (x, y, z, not normalized) and a 16-bit
// binary angle, and returns the upper-left 3x3 of the rotation matrix, saturated. A front
// queue of two requests holds items while the back unit works; the back unit runs an
// iterative cordic of TRIG_ITERATIONS steps (at most TabLen), a rounding step and nine
// element steps through one shared multiply path, and takes a new item only once it is
// through with the last. A result register holds the waiting result so the back unit
// can start the next request meanwhile. Reset needs no clearing pass.
module axis_angle_rotation_matrix_core import aarm_pkg::*; #(
    parameter int FRAC_BITS       = 14,
    parameter int TRIG_ITERATIONS = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic signed [AxisW-1:0]  i_axis_x,
    input  logic signed [AxisW-1:0]  i_axis_y,
    input  logic signed [AxisW-1:0]  i_axis_z,
    input  logic [AngleW-1:0]        i_angle,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic signed [OutW-1:0]   o_m00,
    output logic signed [OutW-1:0]   o_m01,
    output logic signed [OutW-1:0]   o_m02,
    output logic signed [OutW-1:0]   o_m10,
    output logic signed [OutW-1:0]   o_m11,
    output logic signed [OutW-1:0]   o_m12,
    output logic signed [OutW-1:0]   o_m20,
    output logic signed [OutW-1:0]   o_m21,
    output logic signed [OutW-1:0]   o_m22
);

    t_front_item w_item;
    logic w_qv, w_qr;
    logic [OutW-1:0] w_m [9];

    aarm_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_ready,
        .i_axis_x, .i_axis_y, .i_axis_z, .i_angle,
        .o_valid(w_qv), .i_ready(w_qr), .o_item(w_item)
    );

    aarm_back #(.FRAC_BITS(FRAC_BITS), .TRIG_ITERATIONS(TRIG_ITERATIONS)) u_back (
        .i_clk, .i_rst_n, .i_valid(w_qv), .o_ready(w_qr), .i_item(w_item),
        .o_valid, .i_ready, .o_m(w_m)
    );

    assign o_m00 = w_m[0];
    assign o_m01 = w_m[1];
    assign o_m02 = w_m[2];
    assign o_m10 = w_m[3];
    assign o_m11 = w_m[4];
    assign o_m12 = w_m[5];
    assign o_m20 = w_m[6];
    assign o_m21 = w_m[7];
    assign o_m22 = w_m[8];

endmodule

### tb/testbench.sv
// testbench for axis_angle_rotation_matrix_core: drives axis/angle requests, predicts
// the nine saturated matrix elements with its own cordic model, checks every result
// depends on aarm_pkg and axis_angle_rotation_matrix_core
`timescale 1ns / 1ps

module testbench;
    import aarm_pkg::*;

    localparam int Frac = 14;
    localparam int Iters = 16;

    typedef struct packed {
        logic signed [OutW-1:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
    } t_matrix;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_ready;
    logic signed [AxisW-1:0] i_axis_x = '0, i_axis_y = '0, i_axis_z = '0;
    logic [AngleW-1:0] i_angle = '0;
    logic o_valid;
    logic i_ready = 1'b0;
    logic signed [OutW-1:0] o_m00, o_m01, o_m02, o_m10, o_m11, o_m12, o_m20, o_m21, o_m22;

    t_matrix expected_matrices[$];
    int errors = 0;
    bit idle_on = 1'b1;
    int hold_cycles = 0;

    axis_angle_rotation_matrix_core #(.FRAC_BITS(Frac), .TRIG_ITERATIONS(Iters)) i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_axis_x(i_axis_x), .i_axis_y(i_axis_y), .i_axis_z(i_axis_z), .i_angle(i_angle),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_m00(o_m00), .o_m01(o_m01), .o_m02(o_m02), .o_m10(o_m10), .o_m11(o_m11),
        .o_m12(o_m12), .o_m20(o_m20), .o_m21(o_m21), .o_m22(o_m22)
    );

    always #10 i_clk = ~i_clk;

    function automatic longint round_frac(longint v, int sh);
        return (v + (64'sd1 <<< (sh - 1))) >>> sh;
    endfunction

    function automatic logic signed [OutW-1:0] clamp_out(longint v);
        if (v > 131071) return 18'sd131071;
        if (v < -131072) return -18'sd131072;
        return v[OutW-1:0];
    endfunction

    function automatic void trig(logic [15:0] ang, output longint c, output longint s);
        logic [1:0] q;
        logic [15:0] r16;
        longint x, y, z, dx, dy, cr, sr;
        q = 2'((ang + 16'h2000) >> 14);
        r16 = ang - 16'(q) * 16'h4000;
        x = longint'(CordicStart);
        y = 0;
        z = longint'($signed(r16)) * 65536;
        for (int i = 0; i < Iters; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= longint'(atan_entry(5'(i)));
            end else begin
                x += dx; y -= dy; z += longint'(atan_entry(5'(i)));
            end
        end
        case (q)
            2'd0: begin cr = x; sr = y; end
            2'd1: begin cr = -y; sr = x; end
            2'd2: begin cr = -x; sr = -y; end
            default: begin cr = y; sr = -x; end
        endcase
        c = round_frac(cr, CordicFrac - Frac);
        s = round_frac(sr, CordicFrac - Frac);
    endfunction

    function automatic t_matrix rotation_matrix(logic signed [15:0] ax, logic signed [15:0] ay,
                                                logic signed [15:0] az, logic [15:0] ang);
        longint x, y, z, c, s, t, one;
        t_matrix m;
        x = ax; y = ay; z = az;
        one = 64'sd1 <<< Frac;
        trig(ang, c, s);
        t = one - c;
        m.m00 = clamp_out(round_frac(x*x*one + (one*one - x*x)*c, 2*Frac));
        m.m01 = clamp_out(round_frac(x*y*t - z*s*one, 2*Frac));
        m.m02 = clamp_out(round_frac(x*z*t + y*s*one, 2*Frac));
        m.m10 = clamp_out(round_frac(y*x*t + z*s*one, 2*Frac));
        m.m11 = clamp_out(round_frac(y*y*one + (one*one - y*y)*c, 2*Frac));
        m.m12 = clamp_out(round_frac(y*z*t - x*s*one, 2*Frac));
        m.m20 = clamp_out(round_frac(z*x*t - y*s*one, 2*Frac));
        m.m21 = clamp_out(round_frac(z*y*t + x*s*one, 2*Frac));
        m.m22 = clamp_out(round_frac(z*z*one + (one*one - z*z)*c, 2*Frac));
        return m;
    endfunction

    task automatic send_request(logic signed [15:0] ax, logic signed [15:0] ay,
                                logic signed [15:0] az, logic [15:0] ang);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_axis_x <= ax;
        i_axis_y <= ay;
        i_axis_z <= az;
        i_angle <= ang;
        expected_matrices.push_back(rotation_matrix(ax, ay, az, ang));
        do @(posedge i_clk); while (!o_ready);
    endtask

    function automatic logic signed [15:0] rand_axis();
        case ($urandom_range(0, 9))
            0: return 16'($urandom);
            1: return 16'sd16384;
            2: return -16'sd16384;
            default: return 16'($signed($urandom_range(0, 32768)) - 16384);
        endcase
    endfunction

    // receiver with random stalls and one long hold-off
    always @(posedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            i_ready <= 1'b0;
        end else if (idle_on) begin
            i_ready <= ($urandom_range(0, 3) != 0);
        end else begin
            i_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_matrix e;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_matrices.size() == 0) begin
                $error("unexpected result");
                errors++;
            end else begin
                e = expected_matrices.pop_front();
                if (o_m00 !== e.m00) begin $error("m00 exp %0d got %0d", e.m00, o_m00); errors++; end
                if (o_m01 !== e.m01) begin $error("m01 exp %0d got %0d", e.m01, o_m01); errors++; end
                if (o_m02 !== e.m02) begin $error("m02 exp %0d got %0d", e.m02, o_m02); errors++; end
                if (o_m10 !== e.m10) begin $error("m10 exp %0d got %0d", e.m10, o_m10); errors++; end
                if (o_m11 !== e.m11) begin $error("m11 exp %0d got %0d", e.m11, o_m11); errors++; end
                if (o_m12 !== e.m12) begin $error("m12 exp %0d got %0d", e.m12, o_m12); errors++; end
                if (o_m20 !== e.m20) begin $error("m20 exp %0d got %0d", e.m20, o_m20); errors++; end
                if (o_m21 !== e.m21) begin $error("m21 exp %0d got %0d", e.m21, o_m21); errors++; end
                if (o_m22 !== e.m22) begin $error("m22 exp %0d got %0d", e.m22, o_m22); errors++; end
            end
        end
    end

    task automatic test_directed();
        logic [15:0] angs[10] = '{16'h0000, 16'h2000, 16'h1FFF, 16'h4000, 16'h6000,
                                  16'h8000, 16'hC000, 16'hDFFF, 16'hE000, 16'hFFFF};
        foreach (angs[i]) send_request(16'sd16384, 16'sd0, 16'sd0, angs[i]);
        send_request(16'sd0, 16'sd16384, 16'sd0, 16'h4000);
        send_request(16'sd0, 16'sd0, -16'sd16384, 16'h2000);
        send_request(16'sd9459, 16'sd9459, 16'sd9459, 16'h5555);
        send_request(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'h8000);
        send_request(16'sh8000, 16'sh8000, 16'sh8000, 16'h0000);
        send_request(16'sh8000, 16'sh7FFF, 16'sh8000, 16'h4000);
        send_request(16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'hC000);
        send_request(-16'sd16384, 16'sd16384, -16'sd16384, 16'h1234);
        send_request(16'sd0, 16'sd0, 16'sd0, 16'hA5A5);
        send_request(16'shFFFF, 16'sh5555, 16'shAAAA, 16'h5A5A);
    endtask

    task automatic test_random(int n);
        for (int i = 0; i < n; i++)
            send_request(rand_axis(), rand_axis(), rand_axis(), 16'($urandom));
    endtask

    task automatic test_backpressure();
        hold_cycles = 400;
        for (int i = 0; i < 20; i++)
            send_request(rand_axis(), rand_axis(), rand_axis(), 16'($urandom));
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_backpressure();
        test_random(1150);
        idle_on = 1'b0;
        test_random(260);
        i_valid <= 1'b0;
        while (expected_matrices.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (errors == 0)
            $display("axis_angle_rotation_matrix_core: match");
        else
            $display("axis_angle_rotation_matrix_core: mismatch");
        $finish;
    end

    initial begin
        #(20ns * 400000);
        $display("axis_angle_rotation_matrix_core: mismatch");
        $finish;
    end
endmodule
